// File: hw/rtl/touch_zone_navigation_decoder_top_assert.svh
// assertion macros for the decoder top
`ifndef TOUCH_ZONE_NAVIGATION_DECODER_TOP_ASSERT_SVH
`define TOUCH_ZONE_NAVIGATION_DECODER_TOP_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define TZN_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TZN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tzn_pkg.sv
`default_nettype none
package tzn_pkg;

	// direction codes
	typedef enum logic [2:0] {
		NAV_NONE  = 3'd0,
		NAV_BACK  = 3'd1,
		NAV_UP    = 3'd2,
		NAV_PRESS = 3'd3,
		NAV_DOWN  = 3'd4
	} dir_t;

	// register indexes on the config port
	localparam logic [2:0] REG_CAL_X_MIN      = 3'd0;
	localparam logic [2:0] REG_CAL_X_MAX      = 3'd1;
	localparam logic [2:0] REG_CAL_Y_MIN      = 3'd2;
	localparam logic [2:0] REG_CAL_Y_MAX      = 3'd3;
	localparam logic [2:0] REG_SWAP_AXES      = 3'd4;
	localparam logic [2:0] REG_FLIP_BOTH      = 3'd5;
	localparam logic [2:0] REG_RELEASE_MISSES = 3'd6;

	localparam int RAW_W     = 12;
	localparam int SUM_W     = 14;
	localparam int RECIP_SH  = 17;
	localparam int ADDR_W    = 5;
	localparam int Q_DEPTH   = 2;
	localparam int Q_LVL_W   = 2;

	typedef struct packed {
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
		logic             swap;
		logic             flip;
		logic [7:0]       release_misses;
	} cfg_t;

	// classified poll: axis a feeds screen x, axis b feeds screen y
	typedef struct packed {
		logic             hit;
		logic [RAW_W-1:0] num_a;
		logic [RAW_W-1:0] span_a;
		logic [RAW_W-1:0] num_b;
		logic [RAW_W-1:0] span_b;
	} entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/tzn_front.sv
`default_nettype none
module tzn_front #(
	parameter int SAMPLES_PER_AXIS = 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tzn_pkg::cfg_t               cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        pen_down,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_x0,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_x1,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_x2,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_y0,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_y1,
	input  wire logic [tzn_pkg::RAW_W-1:0]   raw_y2,
	output logic                             q_push,
	output tzn_pkg::entry_t                  q_entry,
	input  wire logic                        q_full
);
	localparam int SW = tzn_pkg::SUM_W;
	localparam int NS = (SAMPLES_PER_AXIS > 3) ? 3 : ((SAMPLES_PER_AXIS < 1) ? 1 : SAMPLES_PER_AXIS);
	localparam int RECIP = ((1 << tzn_pkg::RECIP_SH) + NS - 1) / NS;

	logic                             v_s1, v_s2;
	logic                             pen_s1, pen_s2;
	logic [SW-1:0]                    sum_x_s1, sum_y_s1;
	logic [tzn_pkg::RAW_W-1:0]        avg_x_s2, avg_y_s2;
	logic [SW-1:0]                    sum_x, sum_y;
	logic [31:0]                      prod_x, prod_y;
	logic                             adv_s1, hit;

	assign sum_x = SW'(raw_x0) + ((NS >= 2) ? SW'(raw_x1) : '0) + ((NS >= 3) ? SW'(raw_x2) : '0);
	assign sum_y = SW'(raw_y0) + ((NS >= 2) ? SW'(raw_y1) : '0) + ((NS >= 3) ? SW'(raw_y2) : '0);

	// floor divide by sample count as multiply by rounded-up reciprocal
	assign prod_x = 32'(sum_x_s1) * 32'(RECIP);
	assign prod_y = 32'(sum_y_s1) * 32'(RECIP);

	assign q_push   = v_s2 && !q_full;
	assign adv_s1   = !v_s2 || q_push;
	assign in_ready = !v_s1 || adv_s1;

	assign hit = pen_s2 &&
		(avg_x_s2 >= cfg.x_min) && (avg_x_s2 <= cfg.x_max) &&
		(avg_y_s2 >= cfg.y_min) && (avg_y_s2 <= cfg.y_max);

	always_comb begin
		q_entry.hit = hit;
		if (cfg.swap) begin
			q_entry.num_a  = avg_y_s2 - cfg.y_min;
			q_entry.span_a = cfg.y_max - cfg.y_min;
			q_entry.num_b  = avg_x_s2 - cfg.x_min;
			q_entry.span_b = cfg.x_max - cfg.x_min;
		end else begin
			q_entry.num_a  = avg_x_s2 - cfg.x_min;
			q_entry.span_a = cfg.x_max - cfg.x_min;
			q_entry.num_b  = avg_y_s2 - cfg.y_min;
			q_entry.span_b = cfg.y_max - cfg.y_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv_s1)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pen_s1   <= pen_down;
			sum_x_s1 <= sum_x;
			sum_y_s1 <= sum_y;
		end
		if (adv_s1 && v_s1) begin
			pen_s2   <= pen_s1;
			avg_x_s2 <= prod_x[tzn_pkg::RECIP_SH +: tzn_pkg::RAW_W];
			avg_y_s2 <= prod_y[tzn_pkg::RECIP_SH +: tzn_pkg::RAW_W];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tzn_queue.sv
`default_nettype none
module tzn_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire tzn_pkg::entry_t               push_entry,
	output logic                               full,
	input  wire logic                          pop,
	output tzn_pkg::entry_t                    head,
	output logic                               not_empty,
	output logic [tzn_pkg::Q_LVL_W-1:0]        level
);
	tzn_pkg::entry_t                   mem_q [tzn_pkg::Q_DEPTH];
	logic                              wr_q, rd_q;
	logic [tzn_pkg::Q_LVL_W-1:0]       cnt_q;

	assign full      = (cnt_q == tzn_pkg::Q_LVL_W'(tzn_pkg::Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign level     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

endmodule
`default_nettype wire

// File: hw/rtl/tzn_back.sv
`default_nettype none
module tzn_back #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tzn_pkg::cfg_t     cfg,
	input  wire logic              q_not_empty,
	input  wire tzn_pkg::entry_t   q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             direction,
	output logic                   touched,
	output logic [8:0]             touch_x,
	output logic [7:0]             touch_y
);
	localparam int XW = $clog2(SCREEN_WIDTH);
	localparam int YW = $clog2(SCREEN_HEIGHT);
	localparam int QW = (XW > YW) ? XW : YW;
	localparam int DW = tzn_pkg::RAW_W + QW;
	localparam int CW = $clog2(QW);
	localparam int BACK_LIM  = SCREEN_WIDTH / 4;
	localparam int UP_LIM    = SCREEN_HEIGHT / 3;
	localparam int PRESS_LIM = (SCREEN_HEIGHT / 3) * 2;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

	state_t                      state_q;
	tzn_pkg::dir_t               dir_q, dir_new;
	logic [7:0]                  miss_q, miss_inc;
	logic [XW-1:0]               last_x_q, tx_c, tx_f;
	logic [YW-1:0]               last_y_q, ty_c, ty_f;
	logic                        out_valid_q, touched_q, out_set;
	logic [CW-1:0]               cnt_q;

	tzn_pkg::entry_t             ent_q;
	logic [tzn_pkg::RAW_W-1:0]   rem_a_q, rem_b_q, rem_a_n, rem_b_n;
	logic [QW-1:0]               lo_a_q, lo_b_q;
	logic [tzn_pkg::RAW_W:0]     t_a, t_b;
	logic                        ge_a, ge_b, take;
	logic [DW-1:0]               prod_a, prod_b;
	logic [XW-1:0]               q_x;
	logic [YW-1:0]               q_y;
	logic [31:0]                 x32, y32;

	assign take  = !out_valid_q || out_ready;
	assign q_pop = (state_q == ST_IDLE) && q_not_empty && take;

	// a result is produced by a popped miss or a finished touch
	assign out_set = (q_pop && !q_head.hit) || (state_q == ST_DONE);

	// scaled offsets, the dividends of the two mappings
	assign prod_a = DW'(32'(ent_q.num_a) * 32'(SCREEN_WIDTH - 1));
	assign prod_b = DW'(32'(ent_q.num_b) * 32'(SCREEN_HEIGHT - 1));

	// one restoring divide step per axis
	always_comb begin
		t_a = {rem_a_q, lo_a_q[QW-1]};
		t_b = {rem_b_q, lo_b_q[QW-1]};
		ge_a = (t_a >= {1'b0, ent_q.span_a});
		ge_b = (t_b >= {1'b0, ent_q.span_b});
		rem_a_n = ge_a ? tzn_pkg::RAW_W'(t_a - {1'b0, ent_q.span_a}) : t_a[tzn_pkg::RAW_W-1:0];
		rem_b_n = ge_b ? tzn_pkg::RAW_W'(t_b - {1'b0, ent_q.span_b}) : t_b[tzn_pkg::RAW_W-1:0];
	end

	// clamp, flip and zone pick
	always_comb begin
		q_x = (ent_q.span_a == '0) ? '0 : lo_a_q[XW-1:0];
		q_y = (ent_q.span_b == '0) ? '0 : lo_b_q[YW-1:0];
		tx_c = (32'(q_x) >= 32'(SCREEN_WIDTH))  ? XW'(SCREEN_WIDTH - 1)  : q_x;
		ty_c = (32'(q_y) >= 32'(SCREEN_HEIGHT)) ? YW'(SCREEN_HEIGHT - 1) : q_y;
		tx_f = cfg.flip ? XW'(SCREEN_WIDTH - 1) - tx_c : tx_c;
		ty_f = cfg.flip ? YW'(SCREEN_HEIGHT - 1) - ty_c : ty_c;
		if (32'(tx_f) < 32'(BACK_LIM))
			dir_new = tzn_pkg::NAV_BACK;
		else if (32'(ty_f) < 32'(UP_LIM))
			dir_new = tzn_pkg::NAV_UP;
		else if (32'(ty_f) < 32'(PRESS_LIM))
			dir_new = tzn_pkg::NAV_PRESS;
		else
			dir_new = tzn_pkg::NAV_DOWN;
	end

	assign miss_inc = (miss_q == 8'hFF) ? miss_q : miss_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= tzn_pkg::NAV_NONE;
			miss_q      <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
			touched_q   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.hit) begin
							state_q <= ST_MUL;
						end else begin
							miss_q      <= miss_inc;
							if (miss_inc >= cfg.release_misses)
								dir_q <= tzn_pkg::NAV_NONE;
							touched_q   <= 1'b0;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= CW'(QW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE: begin
					miss_q      <= '0;
					dir_q       <= dir_new;
					last_x_q    <= tx_f;
					last_y_q    <= ty_f;
					touched_q   <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			ent_q <= q_head;
		if (state_q == ST_MUL) begin
			rem_a_q <= prod_a[DW-1:QW];
			rem_b_q <= prod_b[DW-1:QW];
			lo_a_q  <= prod_a[QW-1:0];
			lo_b_q  <= prod_b[QW-1:0];
		end else if (state_q == ST_DIV) begin
			rem_a_q <= rem_a_n;
			rem_b_q <= rem_b_n;
			lo_a_q  <= {lo_a_q[QW-2:0], ge_a};
			lo_b_q  <= {lo_b_q[QW-2:0], ge_b};
		end
	end

	assign x32       = 32'(last_x_q);
	assign y32       = 32'(last_y_q);
	assign out_valid = out_valid_q;
	assign direction = dir_q;
	assign touched   = touched_q;
	assign touch_x   = x32[8:0];
	assign touch_y   = y32[7:0];

endmodule
`default_nettype wire

// File: hw/rtl/touch_zone_navigation_decoder_top.sv
// touch zone navigation decoder
// input channel: one request per touch poll (pen_down plus three raw x and
// three raw y converter samples), taken when in_valid and in_ready are high
// output channel: exactly one result per request, in order (direction,
// touched, touch_x, touch_y), taken when out_valid and out_ready are high
// config: apb-style port, registers at byte address 4*index, pready tied high
// path: a request passes the two front stages and the queue; a missed poll
// (pen up or outside the window) gets its result registered when it is popped,
// a touch after the multiply, divide and done states of the back end
// throughput: the front end averages and classifies at one request a cycle
// while the queue is not full; the back end takes one request at a time and
// holds a touch in the shift and subtract divider that maps both axes in
// parallel
// a two-entry queue sits between front and back
// reset clears the direction to none, the miss count and last position to
// zero, and loads the calibration registers with their defaults
// a stalled receiver holds the result; the back end waits, the queue and the
// two front stages fill, and only then in_ready drops
`default_nettype none
`include "touch_zone_navigation_decoder_top_assert.svh"
module touch_zone_navigation_decoder_top #(
	parameter int SCREEN_WIDTH     = 320,
	parameter int SCREEN_HEIGHT    = 240,
	parameter int SAMPLES_PER_AXIS = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// poll requests
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         pen_down,
	input  wire logic [11:0]                  raw_x0,
	input  wire logic [11:0]                  raw_x1,
	input  wire logic [11:0]                  raw_x2,
	input  wire logic [11:0]                  raw_y0,
	input  wire logic [11:0]                  raw_y1,
	input  wire logic [11:0]                  raw_y2,
	// results
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [2:0]                        direction,
	output logic                              touched,
	output logic [8:0]                        touch_x,
	output logic [7:0]                        touch_y,
	// config port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tzn_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	tzn_pkg::cfg_t                    cfg_q;
	logic [2:0]                       reg_idx;
	logic                             cfg_wr;

	logic                             q_push, q_full, q_pop, q_not_empty;
	tzn_pkg::entry_t                  q_in, q_head;
	logic [tzn_pkg::Q_LVL_W-1:0]      q_level;

	// register file, word addressed
	assign pready  = 1'b1;
	assign reg_idx = paddr[tzn_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min          <= 12'd200;
			cfg_q.x_max          <= 12'd3900;
			cfg_q.y_min          <= 12'd200;
			cfg_q.y_max          <= 12'd3900;
			cfg_q.swap           <= 1'b0;
			cfg_q.flip           <= 1'b0;
			cfg_q.release_misses <= 8'd3;
		end else if (cfg_wr) begin
			case (reg_idx)
				tzn_pkg::REG_CAL_X_MIN:      cfg_q.x_min          <= pwdata[11:0];
				tzn_pkg::REG_CAL_X_MAX:      cfg_q.x_max          <= pwdata[11:0];
				tzn_pkg::REG_CAL_Y_MIN:      cfg_q.y_min          <= pwdata[11:0];
				tzn_pkg::REG_CAL_Y_MAX:      cfg_q.y_max          <= pwdata[11:0];
				tzn_pkg::REG_SWAP_AXES:      cfg_q.swap           <= pwdata[0];
				tzn_pkg::REG_FLIP_BOTH:      cfg_q.flip           <= pwdata[0];
				tzn_pkg::REG_RELEASE_MISSES: cfg_q.release_misses <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			tzn_pkg::REG_CAL_X_MIN:      prdata = 32'(cfg_q.x_min);
			tzn_pkg::REG_CAL_X_MAX:      prdata = 32'(cfg_q.x_max);
			tzn_pkg::REG_CAL_Y_MIN:      prdata = 32'(cfg_q.y_min);
			tzn_pkg::REG_CAL_Y_MAX:      prdata = 32'(cfg_q.y_max);
			tzn_pkg::REG_SWAP_AXES:      prdata = 32'(cfg_q.swap);
			tzn_pkg::REG_FLIP_BOTH:      prdata = 32'(cfg_q.flip);
			tzn_pkg::REG_RELEASE_MISSES: prdata = 32'(cfg_q.release_misses);
			default:                     prdata = '0;
		endcase
	end

	// front end: sum, average, window check, axis swap
	tzn_front #(
		.SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pen_down (pen_down),
		.raw_x0   (raw_x0),
		.raw_x1   (raw_x1),
		.raw_x2   (raw_x2),
		.raw_y0   (raw_y0),
		.raw_y1   (raw_y1),
		.raw_y2   (raw_y2),
		.q_push   (q_push),
		.q_entry  (q_in),
		.q_full   (q_full)
	);

	// decouples classification from the divider
	tzn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.not_empty  (q_not_empty),
		.level      (q_level)
	);

	// back end: mapping divide, clamp, flip, zone and release tracking
	tzn_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.direction   (direction),
		.touched     (touched),
		.touch_x     (touch_x),
		.touch_y     (touch_y)
	);

	// a touch always selects a zone
	`TZN_ASSERT_IMPL(a_touch_has_dir, out_valid && touched, direction != tzn_pkg::NAV_NONE, "touch without direction")
	// queue never holds more than its depth
	`TZN_ASSERT_ALWAYS(a_q_level, q_level <= tzn_pkg::Q_LVL_W'(tzn_pkg::Q_DEPTH), "queue overflow")
	// no push into a full queue
	`TZN_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "push while queue full")
	// no pop from an empty queue
	`TZN_ASSERT_IMPL(a_no_pop_empty, q_pop, q_not_empty, "pop while queue empty")

endmodule
`default_nettype wire
